// File: src/lpg_pkg.sv
package lpg_pkg;

  // width of every coordinate field on the channels
  localparam int unsigned FIELD_BITS = 7;
  // default number of coordinate bits actually used
  localparam int unsigned COORD_BITS_DEF = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } lpg_state_e;

  typedef struct packed {
    logic load;   // capture endpoints of an accepted request
    logic setup;  // resolve axes, order and deltas
    logic step;   // emit one pixel pair, advance two steps
  } lpg_cmd_t;

  typedef struct packed {
    logic last_pair;  // current pair is the final one of the line
    logic out_stall;  // output register full and not taken
  } lpg_status_t;

endpackage

// File: src/lpg_line_if.sv
interface lpg_line_if;
  import lpg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] start_x;
  logic [FIELD_BITS-1:0] start_y;
  logic [FIELD_BITS-1:0] end_x;
  logic [FIELD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x,
                input end_y, output ready);
endinterface

// File: src/lpg_pix_if.sv
interface lpg_pix_if;
  import lpg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] first_px_x;
  logic [FIELD_BITS-1:0] first_px_y;
  logic [FIELD_BITS-1:0] second_px_x;
  logic [FIELD_BITS-1:0] second_px_y;
  logic                  second_valid;
  logic                  last_item;

  modport source (output valid, output first_px_x, output first_px_y,
                  output second_px_x, output second_px_y, output second_valid,
                  output last_item, input ready);
  modport sink (input valid, input first_px_x, input first_px_y,
                input second_px_x, input second_px_y, input second_valid,
                input last_item, output ready);
endinterface

// File: src/lpg_ctrl.sv
module lpg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lpg_pkg::lpg_status_t status_i,
  output lpg_pkg::lpg_cmd_t    cmd_o
);
  import lpg_pkg::*;

  lpg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_stall && status_i.last_pair) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.step = !status_i.out_stall;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: src/lpg_dp.sv
module lpg_dp #(
  parameter int unsigned COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lpg_pkg::lpg_cmd_t               cmd_i,
  output lpg_pkg::lpg_status_t            status_o,
  input  logic [lpg_pkg::FIELD_BITS-1:0]  start_x_i,
  input  logic [lpg_pkg::FIELD_BITS-1:0]  start_y_i,
  input  logic [lpg_pkg::FIELD_BITS-1:0]  end_x_i,
  input  logic [lpg_pkg::FIELD_BITS-1:0]  end_y_i,
  input  logic                            pix_ready_i,
  output logic                            pix_valid_o,
  output logic [lpg_pkg::FIELD_BITS-1:0]  first_px_x_o,
  output logic [lpg_pkg::FIELD_BITS-1:0]  first_px_y_o,
  output logic [lpg_pkg::FIELD_BITS-1:0]  second_px_x_o,
  output logic [lpg_pkg::FIELD_BITS-1:0]  second_px_y_o,
  output logic                            second_valid_o,
  output logic                            last_item_o
);
  import lpg_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned CW = COORD_BITS + 1;  // pixel count, up to 2**W
  localparam int unsigned EW = COORD_BITS + 3;  // error, signed, holds twice its peak

  // captured endpoints
  logic [W-1:0] ax_q, ay_q, bx_q, by_q;

  // stepping state
  logic                 steep_q, dec_q;
  logic [W-1:0]         mj_q, mn_q, dmj_q, dmn_q;
  logic signed [EW-1:0] err_q;
  logic [CW-1:0]        left_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [FIELD_BITS-1:0] fx_q, fy_q, sx_q, sy_q;
  logic                  sv_q, last_q;

  // setup logic
  logic [W-1:0] adx, ady, sa_mj, sa_mn, sb_mj, sb_mn;
  logic [W-1:0] p_mj, p_mn, q_mj, q_mn;
  logic         steep, ord;

  // two chained steps
  logic signed [EW-1:0] e1, e2, err1, err2, dmj_s;
  logic                 hit1, hit2;
  logic [W-1:0]         mj1, mn1, mj2, mn2;
  logic                 has_second, last_pair;

  always_comb begin
    adx   = (ax_q > bx_q) ? ax_q - bx_q : bx_q - ax_q;
    ady   = (ay_q > by_q) ? ay_q - by_q : by_q - ay_q;
    steep = ady > adx;
    sa_mj = steep ? ay_q : ax_q;
    sa_mn = steep ? ax_q : ay_q;
    sb_mj = steep ? by_q : bx_q;
    sb_mn = steep ? bx_q : by_q;
    ord   = sa_mj > sb_mj;
    p_mj  = ord ? sb_mj : sa_mj;
    p_mn  = ord ? sb_mn : sa_mn;
    q_mj  = ord ? sa_mj : sb_mj;
    q_mn  = ord ? sa_mn : sb_mn;
  end

  always_comb begin
    dmj_s = signed'(EW'(dmj_q));
    e1    = err_q + signed'(EW'(dmn_q));
    hit1  = (e1 <<< 1) >= dmj_s;
    err1  = hit1 ? e1 - dmj_s : e1;
    mn1   = hit1 ? (dec_q ? mn_q - W'(1) : mn_q + W'(1)) : mn_q;
    mj1   = mj_q + W'(1);
    e2    = err1 + signed'(EW'(dmn_q));
    hit2  = (e2 <<< 1) >= dmj_s;
    err2  = hit2 ? e2 - dmj_s : e2;
    mn2   = hit2 ? (dec_q ? mn1 - W'(1) : mn1 + W'(1)) : mn1;
    mj2   = mj1 + W'(1);
  end

  assign has_second = left_q >= CW'(2);
  assign last_pair  = left_q <= CW'(2);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= start_x_i[W-1:0];
      ay_q <= start_y_i[W-1:0];
      bx_q <= end_x_i[W-1:0];
      by_q <= end_y_i[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      steep_q <= steep;
      mj_q    <= p_mj;
      mn_q    <= p_mn;
      dmj_q   <= q_mj - p_mj;
      dmn_q   <= (p_mn > q_mn) ? p_mn - q_mn : q_mn - p_mn;
      dec_q   <= !(p_mn < q_mn);
      err_q   <= '0;
      left_q  <= CW'(q_mj - p_mj) + CW'(1);
    end else if (cmd_i.step) begin
      mj_q   <= mj2;
      mn_q   <= mn2;
      err_q  <= err2;
      left_q <= last_pair ? '0 : left_q - CW'(2);
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      fx_q   <= FIELD_BITS'(steep_q ? mn_q : mj_q);
      fy_q   <= FIELD_BITS'(steep_q ? mj_q : mn_q);
      sx_q   <= has_second ? FIELD_BITS'(steep_q ? mn1 : mj1) : '0;
      sy_q   <= has_second ? FIELD_BITS'(steep_q ? mj1 : mn1) : '0;
      sv_q   <= has_second;
      last_q <= last_pair;
    end
  end

  always_comb begin
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (pix_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.last_pair = last_pair;
  assign status_o.out_stall = out_valid_q && !pix_ready_i;

  assign pix_valid_o    = out_valid_q;
  assign first_px_x_o   = fx_q;
  assign first_px_y_o   = fy_q;
  assign second_px_x_o  = sx_q;
  assign second_px_y_o  = sy_q;
  assign second_valid_o = sv_q;
  assign last_item_o    = last_q;

endmodule

// File: src/line_pixel_generator.sv
// bresenham line rasteriser, up to two pixels per result
// a taken request goes through setup and emit before its first pair shows
// stepping advances two pixels per cycle while the output is not stalled
// reset: asynchronous, active low; returns to idle with no result pending
// a new line request is taken while the final pair still waits in the output
module line_pixel_generator #(
  parameter int unsigned COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  lpg_line_if.sink  line_i,
  lpg_pix_if.source pix_o
);
  import lpg_pkg::*;

  // command and status between sequencer and stepping datapath
  lpg_cmd_t    cmd;
  lpg_status_t status;

  // sequencer: idle, setup of axes and deltas, one pair per unstalled cycle
  lpg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (line_i.valid),
    .in_ready_o (line_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: endpoint capture, steep swap and ordering, error stepping,
  // output register that parts the result side from the request side
  lpg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .start_x_i      (line_i.start_x),
    .start_y_i      (line_i.start_y),
    .end_x_i        (line_i.end_x),
    .end_y_i        (line_i.end_y),
    .pix_ready_i    (pix_o.ready),
    .pix_valid_o    (pix_o.valid),
    .first_px_x_o   (pix_o.first_px_x),
    .first_px_y_o   (pix_o.first_px_y),
    .second_px_x_o  (pix_o.second_px_x),
    .second_px_y_o  (pix_o.second_px_y),
    .second_valid_o (pix_o.second_valid),
    .last_item_o    (pix_o.last_item)
  );

endmodule

// File: src/lpg_checker.sv
module lpg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [lpg_pkg::FIELD_BITS-1:0] first_px_x_i,
  input logic [lpg_pkg::FIELD_BITS-1:0] second_px_x_i,
  input logic [lpg_pkg::FIELD_BITS-1:0] second_px_y_i,
  input logic                           second_valid_i,
  input logic                           last_item_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(first_px_x_i)
      && $stable(last_item_i))
    else $error("stalled result changed");

  // unused second pixel reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !second_valid_i |-> second_px_x_i == '0 && second_px_y_i == '0)
    else $error("unused second pixel not zero");

  // a lone pixel only closes a line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !second_valid_i |-> last_item_i)
    else $error("single-pixel result before end of line");

  // one line at a time: setup follows each request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken during setup");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (line_i.valid),
  .in_ready_i     (line_i.ready),
  .out_valid_i    (pix_o.valid),
  .out_ready_i    (pix_o.ready),
  .first_px_x_i   (pix_o.first_px_x),
  .second_px_x_i  (pix_o.second_px_x),
  .second_px_y_i  (pix_o.second_px_y),
  .second_valid_i (pix_o.second_valid),
  .last_item_i    (pix_o.last_item)
);
